FILE: design/assert_macros.svh
// assertion macros shared by the wav header parser rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/wavhp_pkg.sv
// types and constants for the wav header parser
// no dependencies

package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LENGTH = 32'd16;
    localparam logic [7:0]  FMT_MAX_RESET  = 8'd128;
    localparam logic [15:0] FORMAT_PCM     = 16'd1;
    localparam logic [15:0] BITS_EIGHT     = 16'd8;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_RLEN,
        PH_WAVE,
        PH_HDR_FMT,
        PH_SKIP_FMT,
        PH_FMT,
        PH_HDR_DATA,
        PH_SKIP_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_RIFF,
        ST_BAD_FMT_LEN,
        ST_NOT_PCM,
        ST_EARLY_END,
        ST_BAD_CHUNK_LEN
    } status_t;

endpackage

FILE: design/wavhp_in_if.sv
// input byte channel of the wav header parser
// no dependencies

interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output first_byte, output stream_end,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input stream_end,
                  output ready);
endinterface

FILE: design/wavhp_out_if.sv
// result channel of the wav header parser
// no dependencies

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] riff_length;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [30:0] sample_count;

    modport source (output valid, output status, output riff_length, output channel_count,
                    output sample_rate, output byte_rate, output block_align,
                    output bits_per_sample, output sample_count, input ready);
    modport sink (input valid, input status, input riff_length, input channel_count,
                  input sample_rate, input byte_rate, input block_align,
                  input bits_per_sample, input sample_count, output ready);
endinterface

FILE: design/wav_header_parser_unit.sv
// wav header parser top level: byte-wide riff/wave parse, at most one result per file
// depends on wavhp_pkg, wavhp_in_if, wavhp_out_if, assert_macros.svh
//
// channel   dir  width  content
// in_ch     in   10     data_byte, first_byte, stream_end
// out_ch    out  178    status and captured header fields, sample_count
// cfg       in   8      fmt_max_length, write only
//
// one beat per cycle while in_ch is ready; the parse state updates on the same edge that takes the beat
// a result is registered and shows in the cycle after the beat that ends the header
// in_ch stalls only while a result is held and out_ch is not ready
// reset puts the parser at the riff tag and fmt_max_length at 128

`include "assert_macros.svh"

module wav_header_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    wavhp_in_if.sink            in_ch,
    wavhp_out_if.source         out_ch
);
    import wavhp_pkg::*;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  pos;
        logic [31:0] skip;
        logic [31:0] word;
        logic [31:0] tag;
        logic [31:0] riff;
        logic [15:0] fmt_tag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic        finished;
    } parse_state_t;

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t cur;
    logic [7:0]   fmt_max_reg;

    logic         emit;
    status_t      emit_status;
    logic [30:0]  emit_count;
    logic         in_acc;

    logic         out_valid_reg;
    logic [2:0]   status_reg;
    logic [31:0]  riff_reg;
    logic [15:0]  chans_reg;
    logic [31:0]  rate_reg;
    logic [31:0]  brate_reg;
    logic [15:0]  align_reg;
    logic [15:0]  bits_reg;
    logic [30:0]  count_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [31:0] word_shift;
        logic [7:0]  pos_inc;
        logic [31:0] skip_dec;
        logic [7:0]  b;

        cur = st_reg;
        if (in_ch.first_byte)
        begin
            cur = '0;
            cur.phase = PH_RIFF;
        end
        st_next     = cur;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_count  = '0;
        b           = in_ch.data_byte;
        word_shift  = {b, cur.word[31:8]};
        pos_inc     = cur.pos + 8'd1;
        skip_dec    = cur.skip - 32'd1;

        if (in_ch.stream_end)
        begin
            if (!cur.finished)
            begin
                emit        = 1'b1;
                emit_status = ST_EARLY_END;
            end
        end
        else if (!cur.finished)
        begin
            case (cur.phase)
                PH_RIFF, PH_RLEN, PH_WAVE:
                begin
                    st_next.word = word_shift;
                    st_next.pos  = pos_inc;
                    if (pos_inc >= 8'd4)
                    begin
                        st_next.pos = '0;
                        if (cur.phase == PH_RIFF)
                        begin
                            if (word_shift != TAG_RIFF)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_RIFF;
                            end
                            else
                            begin
                                st_next.phase = PH_RLEN;
                            end
                        end
                        else if (cur.phase == PH_RLEN)
                        begin
                            st_next.riff  = word_shift;
                            st_next.phase = PH_WAVE;
                        end
                        else if (word_shift != TAG_WAVE)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NOT_RIFF;
                        end
                        else
                        begin
                            st_next.phase = PH_HDR_FMT;
                        end
                    end
                end
                PH_HDR_FMT, PH_HDR_DATA:
                begin
                    st_next.word = word_shift;
                    st_next.pos  = pos_inc;
                    if (pos_inc == 8'd4)
                    begin
                        st_next.tag = word_shift;
                    end
                    if (pos_inc >= 8'd8)
                    begin
                        st_next.pos = '0;
                        if (word_shift[31])
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_CHUNK_LEN;
                        end
                        else if (cur.phase == PH_HDR_FMT && st_next.tag == TAG_FMT)
                        begin
                            if (word_shift < FMT_MIN_LENGTH
                                || word_shift > {24'd0, fmt_max_reg})
                            begin
                                emit        = 1'b1;
                                emit_status = ST_BAD_FMT_LEN;
                            end
                            else
                            begin
                                st_next.skip  = word_shift;
                                st_next.phase = PH_FMT;
                            end
                        end
                        else if (cur.phase == PH_HDR_DATA && st_next.tag == TAG_DATA)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_OK;
                            emit_count  = (cur.bits == BITS_EIGHT) ? word_shift[30:0]
                                                                   : {1'b0, word_shift[30:1]};
                        end
                        else if (word_shift != '0)
                        begin
                            st_next.skip  = word_shift;
                            st_next.phase = (cur.phase == PH_HDR_FMT) ? PH_SKIP_FMT
                                                                      : PH_SKIP_DATA;
                        end
                    end
                end
                PH_SKIP_FMT, PH_SKIP_DATA:
                begin
                    st_next.skip = skip_dec;
                    if (skip_dec == '0)
                    begin
                        st_next.phase = (cur.phase == PH_SKIP_FMT) ? PH_HDR_FMT
                                                                   : PH_HDR_DATA;
                    end
                end
                PH_FMT:
                begin
                    // little-endian field capture by byte offset
                    if (cur.pos < 8'd2)
                        st_next.fmt_tag = cur.fmt_tag | (16'(b) << {cur.pos[0], 3'b000});
                    else if (cur.pos < 8'd4)
                        st_next.chans = cur.chans | (16'(b) << {cur.pos[0], 3'b000});
                    else if (cur.pos < 8'd8)
                        st_next.rate = cur.rate | (32'(b) << {cur.pos[1:0], 3'b000});
                    else if (cur.pos < 8'd12)
                        st_next.brate = cur.brate | (32'(b) << {cur.pos[1:0], 3'b000});
                    else if (cur.pos < 8'd14)
                        st_next.align = cur.align | (16'(b) << {cur.pos[0], 3'b000});
                    else if (cur.pos < 8'd16)
                        st_next.bits = cur.bits | (16'(b) << {cur.pos[0], 3'b000});
                    st_next.pos  = pos_inc;
                    st_next.skip = skip_dec;
                    if (skip_dec == '0)
                    begin
                        st_next.pos = '0;
                        if (st_next.fmt_tag != FORMAT_PCM)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NOT_PCM;
                        end
                        else
                        begin
                            st_next.phase = PH_HDR_DATA;
                        end
                    end
                end
                default:
                begin
                    st_next.phase = PH_RIFF;
                end
            endcase
        end

        if (emit)
        begin
            st_next.finished = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_RIFF, default: '0};
        end
        else if (in_acc)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_max_reg <= FMT_MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            fmt_max_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            status_reg <= emit_status;
            riff_reg   <= st_next.riff;
            chans_reg  <= st_next.chans;
            rate_reg   <= st_next.rate;
            brate_reg  <= st_next.brate;
            align_reg  <= st_next.align;
            bits_reg   <= st_next.bits;
            count_reg  <= emit_count;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.riff_length     = riff_reg;
    assign out_ch.channel_count   = chans_reg;
    assign out_ch.sample_rate     = rate_reg;
    assign out_ch.byte_rate       = brate_reg;
    assign out_ch.block_align     = align_reg;
    assign out_ch.bits_per_sample = bits_reg;
    assign out_ch.sample_count    = count_reg;

    `ASSERT_CLK(a_result_loaded, (in_acc && emit) |=> out_valid_reg,
        "result beat not registered")
    `ASSERT_CLK(a_quiet_when_done, (in_acc && st_reg.finished && !in_ch.first_byte) |-> !emit,
        "result after file already finished")
    `ASSERT_CLK(a_count_only_ok, (out_valid_reg && status_reg != ST_OK) |-> count_reg == '0,
        "nonzero sample count on error result")
    `ASSERT_CLK(a_skip_nonzero,
        (!st_reg.finished && (st_reg.phase == PH_FMT || st_reg.phase == PH_SKIP_FMT
            || st_reg.phase == PH_SKIP_DATA)) |-> st_reg.skip != '0,
        "byte countdown empty inside a chunk")
    `ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> in_ch.ready,
        "input stalled with empty result register")

endmodule

FILE: tb/testbench.sv
// testbench for wav_header_parser_unit: directed and random riff/wave byte streams
// checked against a behavioral parser model kept in this file
// depends on wavhp_pkg, wavhp_in_if, wavhp_out_if and the parser rtl

module testbench;
    import wavhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;

    typedef struct {
        status_t     status;
        logic [31:0] riff_length;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [30:0] sample_count;
    } header_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    wavhp_in_if  in_ch();
    wavhp_out_if out_ch();

    wav_header_parser_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // parser model state
    logic [7:0]  fmt_limit = FMT_MAX_RESET;
    phase_t      parse_phase;
    logic [7:0]  byte_pos;
    logic [31:0] skip_left;
    logic [31:0] shift_word;
    logic [31:0] tag_word;
    logic [31:0] riff_len;
    logic [15:0] fmt_code;
    logic [15:0] chan_cnt;
    logic [31:0] rate_val;
    logic [31:0] brate_val;
    logic [15:0] align_val;
    logic [15:0] bits_val;
    logic        parse_done;

    header_result_t expected_headers[$];
    header_result_t want_hdr;
    logic [7:0]     file_bytes[$];

    bit          pace_on = 1'b1;
    int unsigned junk_len_max = 6;
    int unsigned cycle_count = 0;
    int unsigned beats_sent = 0;
    int unsigned files_sent = 0;
    int unsigned limit_writes = 0;
    int unsigned results_taken = 0;
    int unsigned ready_seen = 0;
    int unsigned out_hold = 0;
    int unsigned mismatches = 0;
    int unsigned status_seen[0:7];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function void clear_parse();
        parse_phase = PH_RIFF;
        byte_pos = '0;
        skip_left = '0;
        shift_word = '0;
        tag_word = '0;
        riff_len = '0;
        fmt_code = '0;
        chan_cnt = '0;
        rate_val = '0;
        brate_val = '0;
        align_val = '0;
        bits_val = '0;
        parse_done = 1'b0;
    endfunction

    function void emit_header(status_t st, logic [30:0] count);
        header_result_t r;
        r.status = st;
        r.riff_length = riff_len;
        r.channel_count = chan_cnt;
        r.sample_rate = rate_val;
        r.byte_rate = brate_val;
        r.block_align = align_val;
        r.bits_per_sample = bits_val;
        r.sample_count = count;
        expected_headers.push_back(r);
        parse_done = 1'b1;
    endfunction

    function void predict_header_byte(logic [7:0] b, logic restart_mark, logic end_mark);
        logic [31:0] len;
        logic [7:0]  p;
        if (restart_mark)
            clear_parse();
        if (end_mark)
        begin
            if (!parse_done)
                emit_header(ST_EARLY_END, '0);
            return;
        end
        if (parse_done)
            return;
        case (parse_phase)
            PH_RIFF, PH_RLEN, PH_WAVE:
            begin
                shift_word = {b, shift_word[31:8]};
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == 8'd4)
                begin
                    byte_pos = '0;
                    if (parse_phase == PH_RIFF)
                    begin
                        if (shift_word != TAG_RIFF)
                            emit_header(ST_NOT_RIFF, '0);
                        else
                            parse_phase = PH_RLEN;
                    end
                    else if (parse_phase == PH_RLEN)
                    begin
                        riff_len = shift_word;
                        parse_phase = PH_WAVE;
                    end
                    else if (shift_word != TAG_WAVE)
                        emit_header(ST_NOT_RIFF, '0);
                    else
                        parse_phase = PH_HDR_FMT;
                end
            end
            PH_HDR_FMT, PH_HDR_DATA:
            begin
                shift_word = {b, shift_word[31:8]};
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == 8'd4)
                    tag_word = shift_word;
                if (byte_pos == 8'd8)
                begin
                    byte_pos = '0;
                    len = shift_word;
                    if (len[31])
                        emit_header(ST_BAD_CHUNK_LEN, '0);
                    else if (parse_phase == PH_HDR_FMT && tag_word == TAG_FMT)
                    begin
                        if (len < FMT_MIN_LENGTH || len > {24'd0, fmt_limit})
                            emit_header(ST_BAD_FMT_LEN, '0);
                        else
                        begin
                            skip_left = len;
                            parse_phase = PH_FMT;
                        end
                    end
                    else if (parse_phase == PH_HDR_DATA && tag_word == TAG_DATA)
                        emit_header(ST_OK, (bits_val == BITS_EIGHT) ? len[30:0] : len[31:1]);
                    else if (len != 0)
                    begin
                        skip_left = len;
                        parse_phase = (parse_phase == PH_HDR_FMT) ? PH_SKIP_FMT : PH_SKIP_DATA;
                    end
                end
            end
            PH_SKIP_FMT, PH_SKIP_DATA:
            begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    parse_phase = (parse_phase == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
            end
            PH_FMT:
            begin
                p = byte_pos;
                if (p < 8'd2)
                    fmt_code[8 * p[0] +: 8] = b;
                else if (p < 8'd4)
                    chan_cnt[8 * p[0] +: 8] = b;
                else if (p < 8'd8)
                    rate_val[8 * p[1:0] +: 8] = b;
                else if (p < 8'd12)
                    brate_val[8 * p[1:0] +: 8] = b;
                else if (p < 8'd14)
                    align_val[8 * p[0] +: 8] = b;
                else if (p < 8'd16)
                    bits_val[8 * p[0] +: 8] = b;
                byte_pos = byte_pos + 8'd1;
                skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                begin
                    byte_pos = '0;
                    if (fmt_code != FORMAT_PCM)
                        emit_header(ST_NOT_PCM, '0);
                    else
                        parse_phase = PH_HDR_DATA;
                end
            end
            default:
                parse_phase = PH_RIFF;
        endcase
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected 0x%08h, got 0x%08h",
                         results_taken, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_taken++;
                status_seen[out_ch.status]++;
                if (expected_headers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with none pending, status %0d",
                                 results_taken, out_ch.status);
                end
                else
                begin
                    want_hdr = expected_headers.pop_front();
                    check_field("status", 32'(want_hdr.status), 32'(out_ch.status));
                    check_field("riff_length", want_hdr.riff_length, out_ch.riff_length);
                    check_field("channel_count", 32'(want_hdr.channel_count),
                                32'(out_ch.channel_count));
                    check_field("sample_rate", want_hdr.sample_rate, out_ch.sample_rate);
                    check_field("byte_rate", want_hdr.byte_rate, out_ch.byte_rate);
                    check_field("block_align", 32'(want_hdr.block_align),
                                32'(out_ch.block_align));
                    check_field("bits_per_sample", 32'(want_hdr.bits_per_sample),
                                32'(out_ch.bits_per_sample));
                    check_field("sample_count", 32'(want_hdr.sample_count),
                                32'(out_ch.sample_count));
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_header_byte(in_ch.data_byte, in_ch.first_byte, in_ch.stream_end);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d results pending",
                     cycle_count, expected_headers.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure, one draw per result beat
    always @(negedge clk)
    begin
        if (ready_seen != results_taken)
        begin
            ready_seen = results_taken;
            out_hold = pace_on ? $urandom_range(0, 19) : 0;
        end
        out_ch.ready <= (out_hold == 0);
        if (out_hold != 0)
            out_hold--;
    end

    function void push8(logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    function void push16(logic [15:0] w);
        push8(w[7:0]);
        push8(w[15:8]);
    endfunction

    function void push32(logic [31:0] w);
        push16(w[15:0]);
        push16(w[31:16]);
    endfunction

    function void push_chunk(logic after_fmt);
        logic [31:0] len;
        int unsigned pick;
        pick = $urandom_range(0, 2);
        len = $urandom_range(0, junk_len_max);
        if (pick == 0)
            push32($urandom);
        else if (pick == 1)
            push32(TAG_LIST);
        else
            push32(after_fmt ? TAG_FMT : TAG_DATA);
        push32(len);
        repeat (len)
            push8(8'($urandom));
    endfunction

    function void make_wav(logic [31:0] fmt_len, logic [15:0] code, logic [15:0] sample_bits,
                           logic [31:0] data_len, int unsigned junk_before,
                           int unsigned junk_after);
        file_bytes.delete();
        push32(TAG_RIFF);
        push32($urandom);
        push32(TAG_WAVE);
        repeat (junk_before)
            push_chunk(1'b0);
        push32(TAG_FMT);
        push32(fmt_len);
        // a refused fmt length ends the file at its header
        if (fmt_len < FMT_MIN_LENGTH || fmt_len > {24'd0, fmt_limit})
            return;
        push16(code);
        push16($urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom));
        push32($urandom);
        push32($urandom);
        push16(16'($urandom));
        push16(sample_bits);
        for (int i = 16; i < 256 && i < fmt_len; i++)
            push8(8'($urandom));
        repeat (junk_after)
            push_chunk(1'b1);
        push32(TAG_DATA);
        push32(data_len);
    endfunction

    function void trim_file(int unsigned keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endfunction

    task send_beat(logic [7:0] b, logic restart_mark, logic end_mark);
        int unsigned gap;
        gap = pace_on ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.first_byte <= restart_mark;
        in_ch.stream_end <= end_mark;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task send_file(logic mark_first, logic add_end);
        foreach (file_bytes[i])
            send_beat(file_bytes[i], mark_first && i == 0, 1'b0);
        if (add_end)
            send_beat(8'($urandom), 1'b0, 1'b1);
        files_sent++;
    endtask

    task drain_results(int unsigned settle);
        while (expected_headers.size() != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    task set_fmt_limit(logic [7:0] value);
        in_ch.valid <= 1'b0;
        drain_results(4);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        fmt_limit = value;
        limit_writes++;
    endtask

    task send_fmt_case(logic [31:0] fmt_len);
        make_wav(fmt_len, FORMAT_PCM, 16'd16, $urandom & 32'h7fff_ffff, 0, 0);
        send_file(1'b1, 1'b0);
    endtask

    task test_header_tags();
        pace_on = 1'b0;
        // first file straight after reset, no restart mark
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd2000, 0, 0);
        send_file(1'b0, 1'b0);
        // stream end together with a restart, before any byte
        send_beat(8'hff, 1'b1, 1'b1);
        // misspelled riff tag
        file_bytes.delete();
        push32(32'h5846_4952);
        send_file(1'b1, 1'b0);
        // misspelled wave tag
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd64, 0, 0);
        file_bytes[11] = 8'h00;
        send_file(1'b1, 1'b0);
        pace_on = 1'b1;
        // early end inside the fmt chunk header
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd64, 0, 0);
        trim_file(18);
        send_file(1'b1, 1'b1);
        // restart in the middle of a file
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd64, 1, 0);
        trim_file(30);
        send_file(1'b1, 1'b0);
        // beats and stream end after the result are ignored
        make_wav(32'd16, FORMAT_PCM, BITS_EIGHT, 32'd77, 1, 1);
        repeat (6)
            push8(8'($urandom));
        send_file(1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task test_fmt_length();
        send_fmt_case(32'd15);
        send_fmt_case(32'd16);
        send_fmt_case(32'd128);
        send_fmt_case(32'd129);
        send_fmt_case(32'h0000_0110);
        send_fmt_case(32'h8000_0010);
        set_fmt_limit(8'd255);
        send_fmt_case(32'd255);
        send_fmt_case(32'd256);
        set_fmt_limit(8'd16);
        send_fmt_case(32'd16);
        send_fmt_case(32'd17);
        set_fmt_limit(8'd15);
        send_fmt_case(32'd16);
        set_fmt_limit(8'd0);
        send_fmt_case(32'd16);
        set_fmt_limit(FMT_MAX_RESET);
    endtask

    task test_format_fields();
        make_wav(32'd16, 16'd3, 16'd16, 32'd100, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd20, 16'h0100, 16'd16, 32'd100, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, 16'hffff, 16'd16, 32'd100, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, BITS_EIGHT, BITS_EIGHT, 32'd1000, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd1001, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, BITS_EIGHT, 32'd0, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd0, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, BITS_EIGHT, 32'h7fff_ffff, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, 16'hffff, 32'h7fff_ffff, 0, 0);
        send_file(1'b1, 1'b0);
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'hffff_ffff, 0, 0);
        send_file(1'b1, 1'b0);
        // extra fmt bytes and skipped chunks on both sides
        make_wav(32'd40, FORMAT_PCM, 16'd24, 32'd4096, 2, 2);
        send_file(1'b1, 1'b0);
        // zero length and single byte chunks
        junk_len_max = 0;
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd500, 2, 2);
        send_file(1'b1, 1'b0);
        junk_len_max = 1;
        make_wav(32'd17, FORMAT_PCM, 16'd16, 32'd500, 2, 2);
        send_file(1'b1, 1'b0);
        junk_len_max = 6;
        // skipped chunk with bit 31 set in its length
        make_wav(32'd16, FORMAT_PCM, 16'd16, 32'd500, 1, 0);
        file_bytes[19] = file_bytes[19] | 8'h80;
        send_file(1'b1, 1'b0);
    endtask

    task test_random_files();
        int unsigned files;
        int unsigned roll;
        int unsigned jb;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        logic [15:0] sample_bits;
        files = 0;
        while (beats_sent < 2000 || files < 6)
        begin
            if (files % 6 == 0)
                pace_on = $urandom_range(0, 3) != 0;
            if (files % 3 == 2)
            begin
                case ($urandom_range(0, 4))
                    0: set_fmt_limit(8'd16);
                    1: set_fmt_limit(8'd255);
                    2: set_fmt_limit(FMT_MAX_RESET);
                    3: set_fmt_limit(8'($urandom_range(16, 255)));
                    default: set_fmt_limit(8'($urandom_range(0, 15)));
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                file_bytes.delete();
                repeat ($urandom_range(1, 12))
                    push8(8'($urandom));
                send_file(1'b1, 1'b1);
            end
            else if (roll == 5)
                send_beat(8'($urandom), 1'b1, 1'b1);
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: fmt_len = 32'd16;
                    6, 7: fmt_len = $urandom_range(16, fmt_limit);
                    8: fmt_len = $urandom_range(0, 15);
                    default: fmt_len = {8'h00, 8'($urandom), 16'($urandom)};
                endcase
                case ($urandom_range(0, 3))
                    0: sample_bits = BITS_EIGHT;
                    1: sample_bits = 16'd16;
                    2: sample_bits = 16'd24;
                    default: sample_bits = 16'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: data_len = 32'd0;
                    1: data_len = 32'h8000_0000 | $urandom;
                    default: data_len = $urandom & 32'h7fff_ffff;
                endcase
                jb = $urandom_range(0, 2);
                make_wav(fmt_len, ($urandom_range(0, 9) != 0) ? FORMAT_PCM : 16'($urandom),
                         sample_bits, data_len, jb, $urandom_range(0, 2));
                if (roll < 10)
                    file_bytes[$urandom_range(0, file_bytes.size() - 1)][$urandom_range(0, 7)]
                        ^= 1'b1;
                else if (roll < 13 && jb != 0)
                    file_bytes[19][7] = 1'b1;
                else if (roll < 23)
                    trim_file($urandom_range(1, file_bytes.size() - 1));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        push8(8'($urandom));
                send_file(1'b1, (roll >= 13 && roll < 18) || $urandom_range(0, 3) == 0);
            end
            files++;
        end
    endtask

    initial
    begin
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.first_byte = 1'b0;
        in_ch.stream_end = 1'b0;
        out_ch.ready = 1'b0;
        clear_parse();
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;

        test_header_tags();
        test_fmt_length();
        test_format_fields();
        test_random_files();

        in_ch.valid <= 1'b0;
        drain_results(8);
        $display("sent %0d files in %0d beats across %0d fmt limit writes, checked %0d results",
                 files_sent, beats_sent, limit_writes, results_taken);
        $display("status mix: ok %0d, tag %0d, fmt len %0d, pcm %0d, early end %0d, chunk len %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0 && expected_headers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
